// ===== src/hds_pkg.sv =====
package hds_pkg;

    // largest grid side the line store holds
    localparam int MAX_SIDE = 64;

    // one input beat: a cell temperature and its jitter factor
    typedef struct packed {
        logic signed [15:0] cell_temp;
        logic        [7:0]  jitter;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic signed [15:0] new_temp;
        logic        [5:0]  out_row;
        logic        [5:0]  out_col;
        logic               last;
    } t_out_item;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GRID_SIDE    = 2'd0,
        CFG_PAD_VALUE    = 2'd1,
        CFG_AIR_TEMP     = 2'd2,
        CFG_AIR_TRANSFER = 2'd3
    } t_cfg_idx;

    // divider operand width and the two constant divisors
    localparam int DIV_W     = 42;
    localparam int MEAN_DIV  = 9;
    localparam int SCALE_DIV = 3276800;
    localparam int SUM_W     = 20;

    // neighbor scan: 0 means -1, 1 means 0, 2 means +1
    localparam logic [1:0] OFS_M1 = 2'd0;
    localparam logic [1:0] OFS_Z  = 2'd1;
    localparam logic [1:0] OFS_P1 = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       rd;
        logic [3:0] k;
        logic [1:0] sel;
        logic       div_start;
        logic       div_sel;
        logic       lat_mean;
        logic       mul1;
        logic       mul2;
        logic       lat_res;
        logic       load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [3:0] flags;
        logic       div_done;
        logic       out_free;
    } t_stat;

    // row offset of scan step k
    function automatic logic [1:0] nb_row(input logic [3:0] k);
        logic [1:0] v;
        case (k)
            4'd0, 4'd1, 4'd2: v = OFS_M1;
            4'd3, 4'd4, 4'd5: v = OFS_Z;
            default:          v = OFS_P1;
        endcase
        return v;
    endfunction

    // column offset of scan step k
    function automatic logic [1:0] nb_col(input logic [3:0] k);
        logic [1:0] v;
        case (k)
            4'd0, 4'd3, 4'd6: v = OFS_M1;
            4'd1, 4'd4, 4'd7: v = OFS_Z;
            default:          v = OFS_P1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/hds_div.sv =====
module hds_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_sel,
    input  logic signed [hds_pkg::DIV_W-1:0] i_dividend,
    output logic                             o_done,
    output logic signed [hds_pkg::DIV_W-1:0] o_quot
);
    import hds_pkg::*;

    // floor by nine: bias by 9 * 2^15 so the operand is positive, then
    // multiply by ceil(2^23 / 9); exact for operands below 2^21
    // floor by 3276800 = 25 * 2^17: shift out 2^17, bias by 25 * 2^19,
    // then multiply by ceil(2^30 / 25); exact for operands below 2^30
    localparam int Y_W        = 25;
    localparam int RCP_W      = 26;
    localparam int PRD_W      = Y_W + RCP_W;
    localparam int MEAN_SH    = 23;
    localparam int SCALE_SH   = 30;
    localparam int SCALE_PRE  = 17;
    localparam int MEAN_BIAS  = 294912;
    localparam int SCALE_BIAS = 13107200;
    localparam int MEAN_OFS   = 32768;
    localparam int SCALE_OFS  = 524288;
    localparam logic [RCP_W-1:0] MEAN_RCP  = RCP_W'(932068);
    localparam logic [RCP_W-1:0] SCALE_RCP = RCP_W'(42949673);

    logic signed [DIV_W-1:0] biased;
    logic                    r_sel;
    logic                    r_stage;
    logic                    r_done;
    logic        [Y_W-1:0]   r_y;
    logic        [PRD_W-1:0] r_prod;
    logic        [PRD_W-1:0] shifted;
    logic signed [DIV_W-1:0] qb;

    // biased positive operand
    assign biased = i_sel ? (i_dividend >>> SCALE_PRE) + DIV_W'(SCALE_BIAS)
                          : i_dividend + DIV_W'(MEAN_BIAS);

    // control: operand cycle, product cycle, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    // data: latch operand, then reciprocal product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sel <= i_sel;
            r_y   <= biased[Y_W-1:0];
        end
        if (r_stage)
            r_prod <= PRD_W'(r_y) * PRD_W'(r_sel ? SCALE_RCP : MEAN_RCP);
    end

    // drop the fraction and remove the bias
    assign shifted = r_sel ? (r_prod >> SCALE_SH) : (r_prod >> MEAN_SH);
    assign qb      = $signed(DIV_W'(shifted));
    assign o_quot  = r_sel ? qb - DIV_W'(SCALE_OFS) : qb - DIV_W'(MEAN_OFS);
    assign o_done  = r_done;

endmodule

// ===== src/hds_dp.sv =====
module hds_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  hds_pkg::t_in_item i_in_data,
    input  hds_pkg::t_cmd     i_cmd,
    output hds_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hds_pkg::t_out_item o_out_data
);
    import hds_pkg::*;

    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW    = CW + 1;
    localparam int DEPTH = 3 * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] MAXW = AW'(MAX_SIDE);

    // configuration
    logic        [6:0]  r_gs;
    logic signed [15:0] r_pad;
    logic signed [15:0] r_air;
    logic        [15:0] r_xfer;

    // raster position and row modulo 3
    logic [CW-1:0] r_row, r_col;
    logic [1:0]    r_rm;
    logic [CW-1:0] r_ir, r_ic;
    logic [1:0]    r_irm;

    logic [SW-1:0] side, side_m1;
    logic          wrap, lastc, lastr;
    logic [CW-1:0] cr, cc;
    logic [1:0]    crm;
    logic [AW-1:0] waddr, raddr;

    logic [CW-1:0] er, ec, nc;
    logic [1:0]    erm, nrm, dr, dc;
    logic          row_ok, col_ok;

    logic [23:0]   r_mem [DEPTH];
    logic [23:0]   r_rdata;
    logic          r_acc_v, r_ok_d, r_ctr_d;
    logic signed [SUM_W-1:0] r_sum;
    logic [7:0]    r_jit;

    logic signed [DIV_W-1:0] dividend, quot;
    logic                    div_done;

    logic signed [15:0] r_mean;
    logic signed [16:0] diff;
    logic signed [33:0] r_p1;
    logic signed [42:0] p2_full;
    logic signed [DIV_W-1:0] r_p2;
    logic signed [42:0] res;
    logic signed [15:0] res_sat, r_res;

    logic               r_ov;
    t_out_item          r_od;

    // effective side: zero acts as one, clipped to the store size
    always_comb begin
        if (r_gs == 7'd0)
            side = SW'(1);
        else if (int'(r_gs) > MAX_SIDE)
            side = SW'(MAX_SIDE);
        else
            side = SW'(r_gs);
    end
    assign side_m1 = side - SW'(1);

    // position of the cell being accepted
    assign wrap  = (SW'(r_row) >= side) || (SW'(r_col) >= side);
    assign cr    = wrap ? '0 : r_row;
    assign cc    = wrap ? '0 : r_col;
    assign crm   = wrap ? 2'd0 : r_rm;
    assign lastc = (SW'(cc) == side_m1);
    assign lastr = (SW'(cr) == side_m1);
    assign waddr = AW'(AW'(crm) * MAXW + AW'(cc));

    assign o_stat.flags[0] = (cr != '0) && (cc != '0);
    assign o_stat.flags[1] = (cr != '0) && lastc;
    assign o_stat.flags[2] = lastr && (cc != '0);
    assign o_stat.flags[3] = lastr && lastc;

    // config port and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= 7'd64;
            r_pad  <= '0;
            r_air  <= '0;
            r_xfer <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_rm   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_SIDE: begin
                    r_gs  <= i_cfg_data[6:0];
                    r_row <= '0;
                    r_col <= '0;
                    r_rm  <= '0;
                end
                CFG_PAD_VALUE:    r_pad  <= $signed(i_cfg_data);
                CFG_AIR_TEMP:     r_air  <= $signed(i_cfg_data);
                CFG_AIR_TRANSFER: r_xfer <= i_cfg_data;
                default: ;
            endcase
        end else if (i_cmd.load_in) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : cr + CW'(1);
                r_rm  <= (lastr || crm == 2'd2) ? 2'd0 : crm + 2'd1;
            end else begin
                r_row <= cr;
                r_col <= cc + CW'(1);
                r_rm  <= crm;
            end
        end
    end

    // latch the accepted cell's position for its emits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ir  <= cr;
            r_ic  <= cc;
            r_irm <= crm;
        end
    end

    // emit target relative to the accepted cell
    assign er  = i_cmd.sel[1] ? r_ir : r_ir - CW'(1);
    assign ec  = i_cmd.sel[0] ? r_ic : r_ic - CW'(1);
    assign erm = i_cmd.sel[1] ? r_irm : ((r_irm == 2'd0) ? 2'd2 : r_irm - 2'd1);

    // neighbor of scan step k
    assign dr = nb_row(i_cmd.k);
    assign dc = nb_col(i_cmd.k);
    always_comb begin
        row_ok = 1'b1;
        col_ok = 1'b1;
        nrm    = erm;
        nc     = ec;
        if (dr == OFS_M1) begin
            row_ok = (er != '0);
            nrm    = (erm == 2'd0) ? 2'd2 : erm - 2'd1;
        end else if (dr == OFS_P1) begin
            row_ok = (SW'(er) != side_m1);
            nrm    = (erm == 2'd2) ? 2'd0 : erm + 2'd1;
        end
        if (dc == OFS_M1) begin
            col_ok = (ec != '0);
            nc     = ec - CW'(1);
        end else if (dc == OFS_P1) begin
            col_ok = (SW'(ec) != side_m1);
            nc     = ec + CW'(1);
        end
    end
    assign raddr = AW'(AW'(nrm) * MAXW + AW'(nc));

    // line store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in)
            r_mem[waddr] <= {i_in_data.cell_temp, i_in_data.jitter};
        if (i_cmd.rd)
            r_rdata <= r_mem[raddr];
    end

    // read pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
            r_ok_d  <= 1'b0;
            r_ctr_d <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.rd;
            r_ok_d  <= row_ok && col_ok;
            r_ctr_d <= i_cmd.rd && (i_cmd.k == 4'd4);
        end
    end

    // 3x3 sum and center jitter
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd && i_cmd.k == 4'd0)
            r_sum <= '0;
        else if (r_acc_v)
            r_sum <= r_sum + (r_ok_d ? SUM_W'($signed(r_rdata[23:8])) : SUM_W'(r_pad));
        if (r_ctr_d)
            r_jit <= r_rdata[7:0];
    end

    // shared divider: mean by nine, then the transfer scale
    assign dividend = i_cmd.div_sel ? r_p2 : DIV_W'(r_sum);

    hds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_sel      (i_cmd.div_sel),
        .i_dividend (dividend),
        .o_done     (div_done),
        .o_quot     (quot)
    );
    assign o_stat.div_done = div_done;

    // relaxation toward ambient
    assign diff    = 17'(r_mean) - 17'(r_air);
    assign p2_full = r_p1 * $signed({1'b0, r_jit});
    assign res     = 43'(r_mean) - 43'(quot);
    always_comb begin
        if (res > 43'sd32767)
            res_sat = 16'sh7fff;
        else if (res < -43'sd32768)
            res_sat = -16'sh8000;
        else
            res_sat = res[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_mean)
            r_mean <= quot[15:0];
        if (i_cmd.mul1)
            r_p1 <= diff * $signed({1'b0, r_xfer});
        if (i_cmd.mul2)
            r_p2 <= p2_full[DIV_W-1:0];
        if (i_cmd.lat_res)
            r_res <= res_sat;
    end

    // output register
    assign o_stat.out_free = !r_ov || !i_out_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (i_cmd.load_out)
            r_ov <= 1'b1;
        else if (!i_out_stall)
            r_ov <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_od.new_temp <= r_res;
            r_od.out_row  <= 6'(er);
            r_od.out_col  <= 6'(ec);
            r_od.last     <= (SW'(er) == side_m1) && (SW'(ec) == side_m1);
        end
    end
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

// ===== src/hds_ctrl.sv =====
module hds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hds_pkg::t_stat i_stat,
    output hds_pkg::t_cmd  o_cmd
);
    import hds_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_ACC  = 10'b0000000100,
        S_DS1  = 10'b0000001000,
        S_DW1  = 10'b0000010000,
        S_MUL1 = 10'b0000100000,
        S_MUL2 = 10'b0001000000,
        S_DS2  = 10'b0010000000,
        S_DW2  = 10'b0100000000,
        S_LOAD = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_pend, n_pend;
    logic [1:0] r_sel, n_sel;
    logic [3:0] r_k, n_k;
    logic [3:0] rest;

    // lowest pending emit goes first
    function automatic logic [1:0] first_set(input logic [3:0] m);
        logic [1:0] v;
        if (m[0])      v = 2'd0;
        else if (m[1]) v = 2'd1;
        else if (m[2]) v = 2'd2;
        else           v = 2'd3;
        return v;
    endfunction

    assign rest = r_pend & ~(4'b0001 << r_sel);

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_sel   = r_sel;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.k   = r_k;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_pend = i_stat.flags;
                    if (i_stat.flags != 4'd0) begin
                        n_sel   = first_set(i_stat.flags);
                        n_k     = 4'd0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (r_k == 4'd8)
                    n_state = S_ACC;
                else
                    n_k = r_k + 4'd1;
            end
            S_ACC: n_state = S_DS1;
            S_DS1: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DW1;
            end
            S_DW1: begin
                if (i_stat.div_done) begin
                    o_cmd.lat_mean = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_DS2;
            end
            S_DS2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state = S_DW2;
            end
            S_DW2: begin
                o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.lat_res = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_pend = rest;
                    if (rest != 4'd0) begin
                        n_sel   = first_set(rest);
                        n_k     = 4'd0;
                        n_state = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_sel   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_sel   <= n_sel;
            r_k     <= n_k;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/heat_diffusion_stencil_top.sv =====
// 3x3 box filter with constant padding over a square grid streamed in raster
// order, each mean then relaxed toward the air temperature. A cell beat that
// completes no neighborhood is taken as soon as it is offered; a beat that completes n
// neighborhoods (one inside the grid, up to four at the bottom right corner)
// holds the input while they are worked out one after another: nine reads
// through the single read port of the line store for each, then two
// reciprocal divisions by constants (by nine and by the transfer scale)
// around the two relaxation multiplies. Output stalls hold the input longer.
// A finished result waits in the output register while the next cell beat is
// taken. Writing grid_side restarts the grid at row 0, column 0.
module heat_diffusion_stencil_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hds_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hds_pkg::t_out_item o_out_data
);
    import hds_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== verif/tb_heat_diffusion_stencil_top.sv =====
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_top;
    import hds_pkg::*;

    localparam int SETTLE_CYC = 600;
    localparam int HOLD_CYC   = 2500;
    localparam longint LIMIT  = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;

    heat_diffusion_stencil_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // predictor state
    logic signed [15:0] cell_mem [3*MAX_SIDE];
    logic        [7:0]  jit_mem  [3*MAX_SIDE];
    int                 cur_row, cur_col;
    logic        [6:0]  side_reg;
    logic signed [15:0] pad_reg, air_reg;
    logic        [15:0] xfer_reg;

    t_out_item   pending_cells[$];
    int          mismatches;
    int          items_sent;
    bit          idle_on;
    bit          hold_req;
    longint      cycles;

    always #6 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall: random bursts, plus a long hold on request
    int hold_left, burst_left;
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 19) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", o_out_data);
            end else begin
                want = pending_cells.pop_front();
                if (o_out_data.new_temp !== want.new_temp ||
                    o_out_data.out_row !== want.out_row ||
                    o_out_data.out_col !== want.out_col ||
                    o_out_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
    end

    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    function automatic int active_side();
        if (side_reg == 0)
            return 1;
        if (side_reg > MAX_SIDE)
            return MAX_SIDE;
        return int'(side_reg);
    endfunction

    function automatic int mem_slot(input int r, input int c);
        return (r % 3) * MAX_SIDE + c;
    endfunction

    // relaxed 3x3 mean of one cell
    function automatic t_out_item relax_cell(input int er, input int ec, input int side);
        t_out_item o;
        longint    sum, mean, prod, res;
        int        nr, nc;
        sum = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = er + dr;
                nc = ec + dc;
                if (nr >= 0 && nc >= 0 && nr < side && nc < side)
                    sum += cell_mem[mem_slot(nr, nc)];
                else
                    sum += pad_reg;
            end
        end
        mean = floor_div(sum, MEAN_DIV);
        prod = (mean - longint'(air_reg)) * longint'(xfer_reg)
             * longint'(jit_mem[mem_slot(er, ec)]);
        res  = mean - floor_div(prod, SCALE_DIV);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        o.new_temp = res[15:0];
        o.out_row  = er[5:0];
        o.out_col  = ec[5:0];
        o.last     = (er == side - 1 && ec == side - 1);
        return o;
    endfunction

    // store one cell and queue the neighborhoods it completes
    task automatic stencil_predict(input logic signed [15:0] t, input logic [7:0] j);
        int side, r, c;
        bit lc, lr;
        side = active_side();
        r = cur_row;
        c = cur_col;
        if (r >= side || c >= side) begin
            r = 0;
            c = 0;
        end
        cell_mem[mem_slot(r, c)] = t;
        jit_mem[mem_slot(r, c)]  = j;
        lc = (c == side - 1);
        lr = (r == side - 1);
        if (r >= 1) begin
            if (c >= 1)
                pending_cells.push_back(relax_cell(r - 1, c - 1, side));
            if (lc)
                pending_cells.push_back(relax_cell(r - 1, c, side));
        end
        if (lr) begin
            if (c >= 1)
                pending_cells.push_back(relax_cell(r, c - 1, side));
            if (lc)
                pending_cells.push_back(relax_cell(r, c, side));
        end
        if (lc) begin
            c = 0;
            r = lr ? 0 : r + 1;
        end else begin
            c++;
        end
        cur_row = r;
        cur_col = c;
    endtask

    // offer one cell beat and wait until it is taken; valid stays high afterward
    task automatic send_cell(input logic signed [15:0] t, input logic [7:0] j);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{cell_temp: t, jitter: j};
        stencil_predict(t, j);
        items_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering, wait for all results, let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write all four registers, block idle
    task automatic set_config(input logic [6:0] side, input logic [15:0] pad,
                              input logic [15:0] air, input logic [15:0] xfer);
        logic [15:0] side_word;
        side_word = {9'($urandom_range(0, 511)), side};
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_GRID_SIDE;    i_cfg_data <= side_word; @(posedge i_clk);
        i_cfg_idx <= CFG_PAD_VALUE;    i_cfg_data <= pad;       @(posedge i_clk);
        i_cfg_idx <= CFG_AIR_TEMP;     i_cfg_data <= air;       @(posedge i_clk);
        i_cfg_idx <= CFG_AIR_TRANSFER; i_cfg_data <= xfer;      @(posedge i_clk);
        i_cfg_we <= 1'b0;
        side_reg = side_word[6:0];
        pad_reg  = pad;
        air_reg  = air;
        xfer_reg = xfer;
        cur_row  = 0;
        cur_col  = 0;
    endtask

    function automatic logic [15:0] rand_temp();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 4095)) - 16'd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_jitter();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return 8'($urandom_range(20, 180));
    endfunction

    function automatic logic [15:0] rand_xfer();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_grids(input int n_grids);
        repeat (n_grids * active_side() * active_side())
            send_cell(rand_temp(), rand_jitter());
    endtask

    // one-cell grids: field extremes, saturation both ways, jitter corners
    task automatic test_corner_cells();
        set_config(7'd1, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_cell(16'sh7FFF, 8'd255);
        send_cell(-16'sh8000, 8'd0);
        send_cell(16'sh0000, 8'd20);
        send_cell(16'sh0001, 8'd180);
        send_cell(-16'sh0001, 8'd128);
        drain();
        // side zero acts as one
        set_config(7'd0, 16'h8000, 16'h7FFF, 16'd32768);
        send_cell(16'sh7FFF, 8'd100);
        send_cell(-16'sh8000, 8'd255);
        send_cell(16'sh5555, 8'h55);
        send_cell(-16'sh2AAB, 8'hAA);
        drain();
    endtask

    // small full grids, grid wrap, first without transfer and then with it
    task automatic test_small_grids();
        set_config(7'd2, 16'h0000, 16'h0000, 16'h0000);
        send_grids(2);
        drain();
        set_config(7'd3, 16'h0100, 16'hFE00, 16'd16384);
        send_grids(1);
        drain();
    endtask

    // side above the maximum acts as the maximum; partial grid then restart
    task automatic test_wide_side();
        set_config(7'd127, 16'h0100, 16'hFE00, 16'd1000);
        repeat (MAX_SIDE + 5) send_cell(rand_temp(), rand_jitter());
        drain();
    endtask

    // long receiver hold while cells keep coming
    task automatic test_output_hold();
        set_config(7'd4, 16'($urandom), 16'($urandom), rand_xfer());
        hold_req = 1'b1;
        send_grids(2);
        drain();
    endtask

    // random settings, mostly whole grids; the tail runs without idling
    task automatic test_random_grids();
        int base, side;
        base = items_sent;
        while (items_sent - base < 40) begin
            if (items_sent - base > 25)
                idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0:       side = 0;
                1:       side = 8;
                default: side = $urandom_range(1, 6);
            endcase
            set_config(7'(side), 16'($urandom), 16'($urandom), rand_xfer());
            if ($urandom_range(0, 5) == 0) begin
                // broken grid, cut short by the next side write
                repeat ($urandom_range(1, active_side() * active_side()))
                    send_cell(rand_temp(), rand_jitter());
            end else if (side <= 4) begin
                send_grids($urandom_range(1, 2));
            end else begin
                send_grids(1);
            end
            drain();
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_GRID_SIDE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        cycles      = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        burst_left  = 0;
        idle_on     = 1'b1;
        side_reg    = 7'd64;
        pad_reg     = '0;
        air_reg     = '0;
        xfer_reg    = '0;
        cur_row     = 0;
        cur_col     = 0;
        foreach (cell_mem[k]) begin
            cell_mem[k] = '0;
            jit_mem[k]  = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cells();
        test_small_grids();
        test_wide_side();
        test_output_hold();
        test_random_grids();

        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_cells.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
